// ----- design/palette_run_length_frame_decoder_assert.svh -----
// Assertion macros for the palette run-length frame decoder.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef PALETTE_RUN_LENGTH_FRAME_DECODER_ASSERT_SVH
`define PALETTE_RUN_LENGTH_FRAME_DECODER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PRLFD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("palette decoder check failed");

// The consequent holds in the cycle after the antecedent.
`define PRLFD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("palette decoder check failed");

`endif

// ----- design/prlfd_pkg.sv -----
package prlfd_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_W = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_H = 2'd2;

  localparam logic [23:0] BG_COLOR_RST = 24'h000000;
  localparam logic [8:0]  CANVAS_W_RST = 9'd160;
  localparam logic [8:0]  CANVAS_H_RST = 9'd120;

  localparam logic [2:0] HDR_TOP    = 3'd0;
  localparam logic [2:0] HDR_BOTTOM = 3'd1;
  localparam logic [2:0] HDR_LEFT   = 3'd2;
  localparam logic [2:0] HDR_DONE   = 3'd4;

  localparam logic [7:0] COLORED_BIT = 8'h80;
  localparam logic [7:0] RUN_MASK    = 8'h7f;

  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  typedef enum logic [1:0] {
    OP_PALETTE = 2'd0,
    OP_STREAM  = 2'd1,
    OP_FRAME   = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data_byte;
    logic [7:0]  entry_index;
    logic [23:0] entry_color;
  } item_t;

  typedef struct packed {
    logic [23:0] bg_color;
    logic [8:0]  canvas_width;
    logic [8:0]  canvas_height;
  } cfg_t;

  typedef struct packed {
    logic [8:0] x;
    logic [8:0] y;
  } pos_t;

  typedef struct packed {
    logic [8:0]  first_x;
    logic [8:0]  first_y;
    logic [8:0]  second_x;
    logic [8:0]  second_y;
    logic        second_valid;
    logic [23:0] pixel_color;
    logic        out_of_canvas;
    logic        last;
  } result_t;

  function automatic pos_t advance(pos_t p, logic [7:0] top, logic [7:0] bottom);
    pos_t       q;
    logic [8:0] y1;
    y1 = p.y + 9'd1;
    if (y1 >= {1'b0, bottom}) begin
      q.y = {1'b0, top};
      q.x = p.x + 9'd1;
    end else begin
      q.y = y1;
      q.x = p.x;
    end
    return q;
  endfunction

  function automatic logic outside(pos_t p, cfg_t c);
    return (p.x >= c.canvas_width) || (p.y >= c.canvas_height);
  endfunction

endpackage

// ----- design/prlfd_front.sv -----
module prlfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_kind,
  input  logic              in_frame_start,
  input  logic [7:0]        in_data_byte,
  input  logic [7:0]        in_entry_index,
  input  logic [23:0]       in_entry_color,
  input  logic              fq_pop,
  output logic              fq_empty,
  output prlfd_pkg::item_t  fq_head
);
  import prlfd_pkg::*;

  item_t            q_mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr_r;
  logic [FQ_AW-1:0] rd_ptr_r;
  logic [FQ_AW:0]   cnt_r;
  item_t            item_c;
  logic             wr_c;

  always_comb begin
    item_c.data_byte   = in_data_byte;
    item_c.entry_index = in_entry_index;
    item_c.entry_color = in_entry_color;
    if (!in_kind) begin
      item_c.op = OP_PALETTE;
    end else if (in_frame_start) begin
      item_c.op = OP_FRAME;
    end else begin
      item_c.op = OP_STREAM;
    end
  end

  assign full     = (cnt_r == (FQ_AW + 1)'(FQ_DEPTH));
  assign fq_empty = (cnt_r == '0);
  assign fq_head  = q_mem_r[rd_ptr_r];
  assign wr_c     = push && !full;

  always_ff @(posedge clk) begin
    if (wr_c) begin
      q_mem_r[wr_ptr_r] <= item_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_c) begin
        wr_ptr_r <= wr_ptr_r + FQ_AW'(1);
      end
      if (fq_pop && !fq_empty) begin
        rd_ptr_r <= rd_ptr_r + FQ_AW'(1);
      end
      case ({wr_c, fq_pop && !fq_empty})
        2'b10:   cnt_r <= cnt_r + (FQ_AW + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (FQ_AW + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- design/prlfd_back.sv -----
module prlfd_back #(
  parameter int PALETTE_DEPTH = prlfd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  prlfd_pkg::cfg_t     cfg,
  input  logic                fq_empty,
  input  prlfd_pkg::item_t    fq_head,
  output logic                fq_pop,
  input  logic                oq_full,
  output logic                oq_push,
  output prlfd_pkg::result_t  oq_data
);
  import prlfd_pkg::*;

  localparam int         PAL_AW    = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PIX  = 3'b010,
    ST_BG   = 3'b100
  } state_t;

  logic [23:0] pal_mem [PALETTE_DEPTH];
  logic [23:0] pal_rd_r;

  state_t     state_r, state_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] top_r, top_nxt;
  logic [7:0] bottom_r, bottom_nxt;
  pos_t       cur_r, cur_nxt;
  logic [6:0] cl_r, cl_nxt;
  logic [6:0] rem_r, rem_nxt;
  logic       pix_ok_r, pix_ok_nxt;

  logic       pal_we;
  logic       rd_en;
  logic [2:0] phase_v;
  logic [6:0] cl_v;
  logic [6:0] run_len;
  pos_t       pos_a;
  pos_t       pos_b;

  assign rd_en   = (state_r == ST_IDLE);
  assign pos_a   = advance(cur_r, top_r, bottom_r);
  assign pos_b   = advance(pos_a, top_r, bottom_r);
  assign phase_v = (fq_head.op == OP_FRAME) ? HDR_TOP : phase_r;
  assign cl_v    = (fq_head.op == OP_FRAME) ? 7'd0 : cl_r;
  assign run_len = 7'(fq_head.data_byte & RUN_MASK);

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[fq_head.entry_index[PAL_AW-1:0]] <= fq_head.entry_color;
    end
    if (rd_en) begin
      pal_rd_r <= pal_mem[fq_head.data_byte[PAL_AW-1:0]];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    top_nxt    = top_r;
    bottom_nxt = bottom_r;
    cur_nxt    = cur_r;
    cl_nxt     = cl_r;
    rem_nxt    = rem_r;
    pix_ok_nxt = pix_ok_r;
    fq_pop     = 1'b0;
    oq_push    = 1'b0;
    oq_data    = '0;
    pal_we     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!fq_empty) begin
          fq_pop = 1'b1;
          case (fq_head.op)
            OP_PALETTE: begin
              pal_we = ({1'b0, fq_head.entry_index} < PAL_LIMIT);
            end
            OP_STREAM, OP_FRAME: begin
              cl_nxt = cl_v;
              if (phase_v < HDR_DONE) begin
                case (phase_v)
                  HDR_TOP: begin
                    top_nxt   = fq_head.data_byte;
                    cur_nxt.y = {1'b0, fq_head.data_byte};
                  end
                  HDR_BOTTOM: bottom_nxt = fq_head.data_byte;
                  HDR_LEFT:   cur_nxt.x  = {1'b0, fq_head.data_byte};
                  default:    ;
                endcase
                phase_nxt = phase_v + 3'd1;
              end else if (cl_v != 7'd0) begin
                cl_nxt     = cl_v - 7'd1;
                pix_ok_nxt = ({1'b0, fq_head.data_byte} < PAL_LIMIT);
                state_nxt  = ST_PIX;
              end else if ((fq_head.data_byte & COLORED_BIT) != 8'd0) begin
                cl_nxt = run_len;
              end else if (run_len != 7'd0) begin
                rem_nxt   = run_len;
                state_nxt = ST_BG;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PIX: begin
        if (!oq_full) begin
          oq_push               = 1'b1;
          oq_data.first_x       = cur_r.x;
          oq_data.first_y       = cur_r.y;
          oq_data.pixel_color   = pix_ok_r ? pal_rd_r : 24'd0;
          oq_data.out_of_canvas = outside(cur_r, cfg);
          oq_data.last          = 1'b1;
          cur_nxt               = pos_a;
          state_nxt             = ST_IDLE;
        end
      end
      ST_BG: begin
        if (!oq_full) begin
          oq_push             = 1'b1;
          oq_data.first_x     = cur_r.x;
          oq_data.first_y     = cur_r.y;
          oq_data.pixel_color = cfg.bg_color;
          oq_data.last        = (rem_r <= 7'd2);
          if (rem_r >= 7'd2) begin
            oq_data.second_x      = pos_a.x;
            oq_data.second_y      = pos_a.y;
            oq_data.second_valid  = 1'b1;
            oq_data.out_of_canvas = outside(cur_r, cfg) || outside(pos_a, cfg);
            cur_nxt               = pos_b;
            rem_nxt               = rem_r - 7'd2;
          end else begin
            oq_data.out_of_canvas = outside(cur_r, cfg);
            cur_nxt               = pos_a;
            rem_nxt               = 7'd0;
          end
          if (rem_r <= 7'd2) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= HDR_DONE;
      top_r    <= '0;
      bottom_r <= '0;
      cur_r    <= '0;
      cl_r     <= '0;
      rem_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      top_r    <= top_nxt;
      bottom_r <= bottom_nxt;
      cur_r    <= cur_nxt;
      cl_r     <= cl_nxt;
      rem_r    <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_ok_r <= pix_ok_nxt;
  end

endmodule

// ----- design/prlfd_outq.sv -----
module prlfd_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                oq_push,
  output logic                oq_full,
  input  prlfd_pkg::result_t  oq_wdata,
  input  logic                oq_pop,
  output logic                oq_empty,
  output prlfd_pkg::result_t  oq_rdata
);
  import prlfd_pkg::*;

  result_t          q_mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r;
  logic [OQ_AW-1:0] rd_ptr_r;
  logic [OQ_AW:0]   cnt_r;
  logic             wr_c;
  logic             rd_c;

  assign oq_full  = (cnt_r == (OQ_AW + 1)'(OQ_DEPTH));
  assign oq_empty = (cnt_r == '0);
  assign oq_rdata = q_mem_r[rd_ptr_r];
  assign wr_c     = oq_push && !oq_full;
  assign rd_c     = oq_pop && !oq_empty;

  always_ff @(posedge clk) begin
    if (wr_c) begin
      q_mem_r[wr_ptr_r] <= oq_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_c) begin
        wr_ptr_r <= wr_ptr_r + OQ_AW'(1);
      end
      if (rd_c) begin
        rd_ptr_r <= rd_ptr_r + OQ_AW'(1);
      end
      case ({wr_c, rd_c})
        2'b10:   cnt_r <= cnt_r + (OQ_AW + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (OQ_AW + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- design/palette_run_length_frame_decoder.sv -----
// Channel   Handshake          Accepted when        Payload
// input     push / full        push && !full        in_kind .. in_entry_color
// result    empty / pop        pop && !empty        out_first_x .. out_last
// config    cfg_we             cfg_we               cfg_index, cfg_data
//
// A palette write, a header byte or a control byte is taken in the idle state.
// A colored pixel starts the registered palette read in ST_IDLE and leaves in ST_PIX.
// Background run of n pixels: ceil(n / 2) results, one per cycle unless oq_full.
// The back-end sequencer handles one item at a time; a four-item input queue and
// a two-result output queue let either side stall without stopping the other.
// Reset is synchronous; the palette is not cleared and holds no value until written.
`include "palette_run_length_frame_decoder_assert.svh"

module palette_run_length_frame_decoder #(
  parameter int PALETTE_DEPTH = prlfd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [prlfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [23:0]                        cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_kind,
  input  logic                               in_frame_start,
  input  logic [7:0]                         in_data_byte,
  input  logic [7:0]                         in_entry_index,
  input  logic [23:0]                        in_entry_color,
  output logic                               empty,
  input  logic                               pop,
  output logic [8:0]                         out_first_x,
  output logic [8:0]                         out_first_y,
  output logic [8:0]                         out_second_x,
  output logic [8:0]                         out_second_y,
  output logic                               out_second_valid,
  output logic [23:0]                        out_pixel_color,
  output logic                               out_of_canvas,
  output logic                               out_last
);
  import prlfd_pkg::*;

  cfg_t    cfg_r;
  logic    fq_empty;
  logic    fq_pop;
  item_t   fq_head;
  logic    bk_push;
  logic    oq_full;
  result_t bk_data;
  result_t oq_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bg_color      <= BG_COLOR_RST;
      cfg_r.canvas_width  <= CANVAS_W_RST;
      cfg_r.canvas_height <= CANVAS_H_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BG_COLOR: cfg_r.bg_color      <= cfg_data;
        REG_CANVAS_W: cfg_r.canvas_width  <= cfg_data[8:0];
        REG_CANVAS_H: cfg_r.canvas_height <= cfg_data[8:0];
        default:      ;
      endcase
    end
  end

  prlfd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_kind        (in_kind),
    .in_frame_start (in_frame_start),
    .in_data_byte   (in_data_byte),
    .in_entry_index (in_entry_index),
    .in_entry_color (in_entry_color),
    .fq_pop         (fq_pop),
    .fq_empty       (fq_empty),
    .fq_head        (fq_head)
  );

  prlfd_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .fq_empty (fq_empty),
    .fq_head  (fq_head),
    .fq_pop   (fq_pop),
    .oq_full  (oq_full),
    .oq_push  (bk_push),
    .oq_data  (bk_data)
  );

  prlfd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .oq_push  (bk_push),
    .oq_full  (oq_full),
    .oq_wdata (bk_data),
    .oq_pop   (pop),
    .oq_empty (empty),
    .oq_rdata (oq_rdata)
  );

  assign out_first_x      = oq_rdata.first_x;
  assign out_first_y      = oq_rdata.first_y;
  assign out_second_x     = oq_rdata.second_x;
  assign out_second_y     = oq_rdata.second_y;
  assign out_second_valid = oq_rdata.second_valid;
  assign out_pixel_color  = oq_rdata.pixel_color;
  assign out_of_canvas    = oq_rdata.out_of_canvas;
  assign out_last         = oq_rdata.last;

  `PRLFD_ASSERT_IMP(a_oq_no_overflow, bk_push, !oq_full)
  `PRLFD_ASSERT_IMP(a_fq_pop_nonempty, fq_pop, !fq_empty)
  `PRLFD_ASSERT_IMP(a_second_zero, !empty && !out_second_valid, ~|(out_second_x | out_second_y))
  `PRLFD_ASSERT_NXT(a_fq_fill, push && !full && !fq_pop, !fq_empty)

endmodule
